// ===== sv/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, types and arithmetic helpers for the stereo ping-pong
// delay.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int STORE_DEPTH   = 65536;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W      = 16;
   localparam int DELAY_W       = 16;
   localparam int GAIN_W        = 15;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int FIFO_PTR_W    = 1;
   localparam int FIFO_DEPTH    = 1 << FIFO_PTR_W;

   localparam int DELAY_RESET   = 22050;
   localparam int FB_MAX        = 31130;
   localparam int MIX_THRESHOLD = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LENGTH  = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1,
      CSR_MIX_GAIN      = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type              left;
      sample_type              right;
      logic                    bypass;
      logic                    rd_valid;
      logic [ADDR_W-1:0]       rd_addr;
      logic [ADDR_W-1:0]       wr_addr;
   } spd_entry_type;

   typedef struct packed {
      logic [GAIN_W-1:0]       feedback;
      logic [GAIN_W-1:0]       mix;
   } spd_cfg_type;

   // sample * gain, rounded half up back to Q1.15 (17 bits to hold the range)
   function automatic logic signed [SAMPLE_W:0] mul_round(
      input sample_type s, input logic [GAIN_W-1:0] g);
      logic signed [SAMPLE_W-1:0] gs;
      logic signed [31:0]         p;
      gs = $signed({1'b0, g});
      p  = s * gs;
      p  = p + 32'sd16384;
      return p[31:15];
   endfunction

   function automatic sample_type sat_add(
      input sample_type s, input logic signed [SAMPLE_W:0] m);
      logic signed [SAMPLE_W+1:0] sum;
      sum = $signed({{2{s[SAMPLE_W-1]}}, s}) + $signed({m[SAMPLE_W], m});
      if (sum > 18'sd32767) begin
         return 16'sh7fff;
      end else if (sum < -18'sd32768) begin
         return 16'sh8000;
      end
      return sum[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== sv/spd_if.sv =====
// ----------------------------------------------------------------------------
// spd_if
// Valid/ready channel interfaces: sample input, sample output, register write.
// ----------------------------------------------------------------------------
interface spd_req_if;
   import spd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface spd_rsp_if;
   import spd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface spd_csr_if;
   import spd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/spd_ram.sv =====
// ----------------------------------------------------------------------------
// spd_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/spd_front.sv =====
// ----------------------------------------------------------------------------
// spd_front
// Register file, bypass decision, read/write address generation and fill
// tracking. Pushes one classified entry per accepted beat.
// ----------------------------------------------------------------------------
module spd_front (
   input  logic                  clock,
   input  logic                  reset,
   spd_req_if.sink               req_if,
   spd_csr_if.sink               csr_if,
   input  logic                  fifo_full,
   output logic                  push,
   output spd_pkg::spd_entry_type push_entry,
   output spd_pkg::spd_cfg_type   cfg
);
   import spd_pkg::*;

   localparam int CW = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;

   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [GAIN_W-1:0]  fb_ff, fb_in;
   logic [GAIN_W-1:0]  mix_ff, mix_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic               wrapped_ff, wrapped_in;

   logic [CW-1:0]      d_ext;
   logic [ADDR_W-1:0]  d_clamp;
   logic [ADDR_W:0]    rp_wide;
   logic               bypass;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !fifo_full;
   assign push         = req_if.valid && !fifo_full;
   assign bypass       = (mix_ff <= GAIN_W'(MIX_THRESHOLD));

   always_comb begin
      delay_in = delay_ff;
      fb_in    = fb_ff;
      mix_in   = mix_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DELAY_LENGTH:  delay_in = csr_if.data[DELAY_W-1:0];
            CSR_FEEDBACK_GAIN: fb_in    = csr_if.data[GAIN_W-1:0];
            CSR_MIX_GAIN:      mix_in   = csr_if.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      d_ext = CW'(delay_ff);
      if (d_ext == '0) begin
         d_ext = CW'(1);
      end else if (d_ext > CW'(STORE_DEPTH - 1)) begin
         d_ext = CW'(STORE_DEPTH - 1);
      end
      d_clamp = d_ext[ADDR_W-1:0];
      if (wp_ff >= d_clamp) begin
         rp_wide = {1'b0, wp_ff} - {1'b0, d_clamp};
      end else begin
         rp_wide = {1'b0, wp_ff} + (ADDR_W+1)'(STORE_DEPTH) - {1'b0, d_clamp};
      end
   end

   always_comb begin
      push_entry.left     = req_if.left_in;
      push_entry.right    = req_if.right_in;
      push_entry.bypass   = bypass;
      push_entry.rd_addr  = rp_wide[ADDR_W-1:0];
      push_entry.wr_addr  = wp_ff;
      push_entry.rd_valid = wrapped_ff || (rp_wide[ADDR_W-1:0] < wp_ff);
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (push && !bypass) begin
         if (wp_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   assign cfg.feedback = (fb_ff > GAIN_W'(FB_MAX)) ? GAIN_W'(FB_MAX) : fb_ff;
   assign cfg.mix      = mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= DELAY_W'(DELAY_RESET);
         fb_ff      <= '0;
         mix_ff     <= '0;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         delay_ff   <= delay_in;
         fb_ff      <= fb_in;
         mix_ff     <= mix_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

endmodule

// ===== sv/spd_fifo.sv =====
// ----------------------------------------------------------------------------
// spd_fifo
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module spd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  spd_pkg::spd_entry_type push_entry,
   input  logic                   pop,
   output logic                   valid,
   output logic                   full,
   output spd_pkg::spd_entry_type head
);
   import spd_pkg::*;

   spd_entry_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign valid   = (count_ff != '0);
   assign full    = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/spd_back.sv =====
// ----------------------------------------------------------------------------
// spd_back
// Delay stores, cross-feed and wet mix. Reads at dequeue, computes and writes
// back when the entry moves into the output register.
// ----------------------------------------------------------------------------
module spd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fifo_valid,
   input  spd_pkg::spd_entry_type fifo_head,
   output logic                   pop,
   input  spd_pkg::spd_cfg_type   cfg,
   spd_rsp_if.source              rsp_if
);
   import spd_pkg::*;

   spd_entry_type s1_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          fwd_valid_ff;
   sample_type    fwd_l_ff, fwd_r_ff;
   logic          out_valid_ff, out_valid_in;
   sample_type    out_l_ff, out_r_ff;

   logic          s1_adv, rd_en, wr_en, fwd_hit;
   sample_type    ram_l, ram_r, dl, dr;
   sample_type    st_l, st_r, wet_l, wet_r, res_l, res_r;

   assign s1_adv  = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign pop     = fifo_valid && (!s1_valid_ff || s1_adv);
   assign rd_en   = pop && !fifo_head.bypass;
   assign wr_en   = s1_adv && !s1_ff.bypass;
   assign fwd_hit = wr_en && (fifo_head.rd_addr == s1_ff.wr_addr);

   spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.wr_addr),
      .wr_data (st_l),
      .rd_en   (rd_en),
      .rd_addr (fifo_head.rd_addr),
      .rd_data (ram_l)
   );

   spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.wr_addr),
      .wr_data (st_r),
      .rd_en   (rd_en),
      .rd_addr (fifo_head.rd_addr),
      .rd_data (ram_r)
   );

   // never-written entries read as zero
   always_comb begin
      if (fwd_valid_ff) begin
         dl = fwd_l_ff;
         dr = fwd_r_ff;
      end else if (s1_ff.rd_valid) begin
         dl = ram_l;
         dr = ram_r;
      end else begin
         dl = '0;
         dr = '0;
      end
      st_l  = sat_add(s1_ff.left,  mul_round(dr, cfg.feedback));
      st_r  = sat_add(s1_ff.right, mul_round(dl, cfg.feedback));
      wet_l = sat_add(s1_ff.left,  mul_round(dl, cfg.mix));
      wet_r = sat_add(s1_ff.right, mul_round(dr, cfg.mix));
      res_l = s1_ff.bypass ? s1_ff.left  : wet_l;
      res_r = s1_ff.bypass ? s1_ff.right : wet_r;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            fwd_valid_ff <= fwd_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff    <= fifo_head;
         fwd_l_ff <= st_l;
         fwd_r_ff <= st_r;
      end
      if (s1_adv) begin
         out_l_ff <= res_l;
         out_r_ff <= res_r;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.left_out  = out_l_ff;
   assign rsp_if.right_out = out_r_ff;

endmodule

// ===== sv/stereo_ping_pong_delay.sv =====
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay
// Stereo ping-pong feedback delay on Q1.15 sample pairs.
// ----------------------------------------------------------------------------
// Accepts one stereo pair per clock unless stalled and returns one result per
// pair, in order. Each store has one write and one read port, and every pair
// not bypassed uses one of each, which sets the rate at one pair per cycle. A
// pair read one sample back is forwarded from the write of the pair before it.
// Stores need no clearing pass after reset: unwritten entries are tracked by
// the write pointer and a wrapped flag and read as zero. With mix_gain at 32
// or less pairs pass through and the stores and pointer hold. The user must
// write registers only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay (
   input  logic       clock,
   input  logic       reset,
   spd_req_if.sink    req_if,
   spd_rsp_if.source  rsp_if,
   spd_csr_if.sink    csr_if
);
   import spd_pkg::*;

   logic          push, pop, fifo_full, fifo_valid;
   spd_entry_type push_entry, fifo_head;
   spd_cfg_type   cfg;

   spd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   spd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .valid      (fifo_valid),
      .full       (fifo_full),
      .head       (fifo_head)
   );

   spd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (fifo_valid),
      .fifo_head  (fifo_head),
      .pop        (pop),
      .cfg        (cfg),
      .rsp_if     (rsp_if)
   );

endmodule
